[src/lbvs_pkg.sv]
// Shared types, constants and saturation helper for the vertex skinning pipeline.
package lbvs_pkg;

	localparam int ENTRIES = 12;
	localparam int INFLUENCES = 4;
	localparam int ROWS = 3;

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_SKIN = 1'b1
	} op_t;

	// One bone's 3x4 matrix, row-major, entry e in lane e.
	typedef logic [ENTRIES-1:0][31:0] mat_t;

	typedef struct packed {
		logic [ROWS-1:0][31:0] pos;
		logic [ROWS-1:0][15:0] nrm;
	} vtx_t;

	// What travels beside the square root and the divider.
	typedef struct packed {
		logic [ROWS-1:0][31:0] pos;
		logic [ROWS-1:0][30:0] mag;
		logic [ROWS-1:0]       neg;
		logic                  zero;
	} side_t;

	function automatic logic [31:0] sat32(input logic signed [50:0] x);
		logic [31:0] r;
		if (x > 51'sd2147483647) begin
			r = 32'h7fff_ffff;
		end else if (x < -51'sd2147483648) begin
			r = 32'h8000_0000;
		end else begin
			r = x[31:0];
		end
		return r;
	endfunction

endpackage

[src/lbvs_blend.sv]
// Bone store, influence sequencer and weighted blend of four bone matrices.
module lbvs_blend #(
	parameter int NUM_BONES = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                op,
	input  logic [5:0]          bone_slot,
	input  logic [3:0]          entry_index,
	input  logic signed [31:0]  entry_value,
	input  logic signed [31:0]  pos_x,
	input  logic signed [31:0]  pos_y,
	input  logic signed [31:0]  pos_z,
	input  logic signed [15:0]  nrm_x,
	input  logic signed [15:0]  nrm_y,
	input  logic signed [15:0]  nrm_z,
	input  logic [63:0]         weights_packed,
	input  logic [23:0]         bones_packed,
	output logic                t_valid,
	output lbvs_pkg::mat_t      t,
	output lbvs_pkg::vtx_t      vtx
);

	localparam int AW = (NUM_BONES > 1) ? $clog2(NUM_BONES) : 1;
	localparam int KW = $clog2(lbvs_pkg::INFLUENCES);
	localparam int NE = lbvs_pkg::ENTRIES;

	lbvs_pkg::mat_t mem [NUM_BONES];

	logic           busy_q;
	logic [KW-1:0]  cnt_q;
	lbvs_pkg::vtx_t vtx_q;
	logic [63:0]    wts_q;
	logic [23:0]    bones_q;

	logic           accept;
	logic           start;
	logic           issue;
	logic           write_en;
	logic [KW-1:0]  k;
	logic [5:0]     bone;
	logic [15:0]    wt;
	logic [8:0]     bone9;
	logic [8:0]     slot9;
	logic           inr;
	lbvs_pkg::vtx_t vtx_in;
	lbvs_pkg::vtx_t vtx_cur;

	logic                  v_s1, first_s1, last_s1, inr_s1;
	logic [15:0]           w_s1;
	lbvs_pkg::mat_t        rd_row_s1;
	lbvs_pkg::vtx_t        vtx_s1;
	logic                  v_s2, first_s2, last_s2;
	logic signed [48:0]    prod_s2 [NE];
	lbvs_pkg::vtx_t        vtx_s2;
	logic                  v_s3;
	logic signed [49:0]    acc_s3 [NE];
	lbvs_pkg::vtx_t        vtx_s3;
	logic                  v_s4;
	lbvs_pkg::mat_t        t_s4;
	lbvs_pkg::vtx_t        vtx_s4;

	assign in_ready = adv & ~busy_q;
	assign accept   = in_valid & in_ready;
	assign start    = accept & (op == lbvs_pkg::OP_SKIN);
	assign slot9    = 9'(bone_slot);
	assign write_en = accept & (op == lbvs_pkg::OP_LOAD) & (entry_index < 4'(NE))
		& (slot9 < 9'(NUM_BONES));
	assign issue    = start | (busy_q & adv);

	assign vtx_in.pos = {pos_z, pos_y, pos_x};
	assign vtx_in.nrm = {nrm_z, nrm_y, nrm_x};

	// The first influence is read straight from the ports on the transfer itself.
	always_comb begin
		if (start) begin
			k       = '0;
			bone    = bones_packed[5:0];
			wt      = weights_packed[15:0];
			vtx_cur = vtx_in;
		end else begin
			k       = cnt_q;
			bone    = bones_q[6*cnt_q +: 6];
			wt      = wts_q[16*cnt_q +: 16];
			vtx_cur = vtx_q;
		end
		bone9 = 9'(bone);
		inr   = bone9 < 9'(NUM_BONES);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= KW'(1);
		end else if (busy_q && adv) begin
			cnt_q <= cnt_q + KW'(1);
			if (cnt_q == KW'(lbvs_pkg::INFLUENCES - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			vtx_q   <= vtx_in;
			wts_q   <= weights_packed;
			bones_q <= bones_packed;
		end
	end

	always_ff @(posedge clk) begin
		if (write_en) begin
			mem[slot9[AW-1:0]][entry_index] <= entry_value;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			rd_row_s1 <= mem[bone9[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2 & last_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			first_s1 <= (k == '0);
			last_s1  <= (k == KW'(lbvs_pkg::INFLUENCES - 1));
			w_s1     <= wt;
			inr_s1   <= inr;
			vtx_s1   <= vtx_cur;

			first_s2 <= first_s1;
			last_s2  <= last_s1;
			vtx_s2   <= vtx_s1;
			for (int e = 0; e < NE; e++) begin
				if (inr_s1) begin
					prod_s2[e] <= $signed({1'b0, w_s1}) * $signed(rd_row_s1[e]);
				end else begin
					prod_s2[e] <= '0;
				end
			end

			if (v_s2) begin
				for (int e = 0; e < NE; e++) begin
					if (first_s2) begin
						acc_s3[e] <= 50'(prod_s2[e]);
					end else begin
						acc_s3[e] <= acc_s3[e] + 50'(prod_s2[e]);
					end
				end
				if (last_s2) begin
					vtx_s3 <= vtx_s2;
				end
			end

			for (int e = 0; e < NE; e++) begin
				t_s4[e] <= lbvs_pkg::sat32((51'(acc_s3[e]) + 51'sd16384) >>> 15);
			end
			vtx_s4 <= vtx_s3;
		end
	end

	assign t_valid = v_s4;
	assign t       = t_s4;
	assign vtx     = vtx_s4;

endmodule

[src/lbvs_xform.sv]
// Position and normal transform, normal scaling and sum of squares.
module lbvs_xform (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            adv,
	input  logic            in_valid,
	input  lbvs_pkg::mat_t  t,
	input  lbvs_pkg::vtx_t  vtx,
	output logic            out_valid,
	output logic [63:0]     rad,
	output lbvs_pkg::side_t side
);

	localparam int R = lbvs_pkg::ROWS;

	logic [8:0] vld_s;

	logic signed [63:0] pp_s1 [R][R];
	logic signed [47:0] np_s1 [R][R];
	logic signed [31:0] t3_s1 [R];
	logic signed [65:0] psum_s2 [R];
	logic signed [49:0] nsum_s2 [R];
	logic signed [31:0] t3_s2 [R];
	logic [R-1:0][31:0] pos_s3, pos_s4, pos_s5, pos_s6;
	logic signed [49:0] nv_s3 [R];
	logic signed [49:0] nv_s4 [R];
	logic signed [49:0] nv_s5 [R];
	logic [48:0]        mag_s3 [R];
	logic [48:0]        max_s4;
	logic [5:0]         lead_s5;
	logic signed [31:0] vs_s6 [R];
	logic               zero_s3, zero_s4, zero_s5, zero_s6;
	lbvs_pkg::side_t    side_s7, side_s8, side_s9;
	logic [61:0]        sq_s8 [R];
	logic [63:0]        rad_s9;

	function automatic logic [48:0] abs50(input logic signed [49:0] v);
		logic signed [49:0] a;
		a = (v < 0) ? -v : v;
		return a[48:0];
	endfunction

	function automatic logic [5:0] lead1(input logic [48:0] m);
		logic [5:0] p;
		p = '0;
		for (int i = 0; i < 49; i++) begin
			if (m[i]) begin
				p = 6'(i);
			end
		end
		return p;
	endfunction

	// Brings the largest component into [2^29, 2^30); right shifts round down.
	function automatic logic [31:0] norm_shift(input logic signed [49:0] v,
		input logic [5:0] lead);
		logic signed [49:0] s;
		if (lead > 6'd29) begin
			s = v >>> (lead - 6'd29);
		end else begin
			s = v <<< (6'd29 - lead);
		end
		return s[31:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[7:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int r = 0; r < R; r++) begin
				for (int c = 0; c < R; c++) begin
					pp_s1[r][c] <= $signed(t[4*r+c]) * $signed(vtx.pos[c]);
					np_s1[r][c] <= $signed(t[4*r+c]) * $signed(vtx.nrm[c]);
				end
				t3_s1[r] <= $signed(t[4*r+3]);
			end

			for (int r = 0; r < R; r++) begin
				psum_s2[r] <= 66'(pp_s1[r][0]) + 66'(pp_s1[r][1]) + 66'(pp_s1[r][2])
					+ 66'sd32768;
				nsum_s2[r] <= 50'(np_s1[r][0]) + 50'(np_s1[r][1]) + 50'(np_s1[r][2]);
				t3_s2[r]   <= t3_s1[r];
			end

			for (int r = 0; r < R; r++) begin
				pos_s3[r] <= lbvs_pkg::sat32(51'(psum_s2[r] >>> 16) + 51'(t3_s2[r]));
				nv_s3[r]  <= nsum_s2[r];
				mag_s3[r] <= abs50(nsum_s2[r]);
			end
			zero_s3 <= (nsum_s2[0] == 0) && (nsum_s2[1] == 0) && (nsum_s2[2] == 0);

			pos_s4  <= pos_s3;
			nv_s4   <= nv_s3;
			zero_s4 <= zero_s3;
			if (mag_s3[0] >= mag_s3[1] && mag_s3[0] >= mag_s3[2]) begin
				max_s4 <= mag_s3[0];
			end else if (mag_s3[1] >= mag_s3[2]) begin
				max_s4 <= mag_s3[1];
			end else begin
				max_s4 <= mag_s3[2];
			end

			pos_s5  <= pos_s4;
			nv_s5   <= nv_s4;
			zero_s5 <= zero_s4;
			lead_s5 <= lead1(max_s4);

			pos_s6  <= pos_s5;
			zero_s6 <= zero_s5;
			for (int r = 0; r < R; r++) begin
				vs_s6[r] <= $signed(norm_shift(nv_s5[r], lead_s5));
			end

			side_s7.pos  <= pos_s6;
			side_s7.zero <= zero_s6;
			for (int r = 0; r < R; r++) begin
				side_s7.neg[r] <= vs_s6[r][31];
				side_s7.mag[r] <= vs_s6[r][31] ? 31'(32'd0 - 32'(vs_s6[r])) : vs_s6[r][30:0];
			end

			side_s8 <= side_s7;
			for (int r = 0; r < R; r++) begin
				sq_s8[r] <= 62'(side_s7.mag[r]) * 62'(side_s7.mag[r]);
			end

			side_s9 <= side_s8;
			rad_s9  <= 64'(sq_s8[0]) + 64'(sq_s8[1]) + 64'(sq_s8[2]);
		end
	end

	assign out_valid = vld_s[8];
	assign rad       = rad_s9;
	assign side      = side_s9;

endmodule

[src/lbvs_sqrt.sv]
// Pipelined integer square root, two result bits per stage.
module lbvs_sqrt (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            adv,
	input  logic            in_valid,
	input  logic [63:0]     rad,
	input  lbvs_pkg::side_t side_in,
	output logic            out_valid,
	output logic [31:0]     len,
	output lbvs_pkg::side_t side_out
);

	localparam int STAGES = 16;

	logic [STAGES-1:0] vld_s;
	logic [35:0]       rem_s  [STAGES];
	logic [31:0]       root_s [STAGES];
	logic [63:0]       rad_s  [STAGES];
	lbvs_pkg::side_t   side_s [STAGES];

	logic [35:0] rem_n  [STAGES];
	logic [31:0] root_n [STAGES];
	logic [63:0] rad_n  [STAGES];

	always_comb begin
		logic [35:0] r;
		logic [35:0] trial;
		logic [31:0] q;
		logic [63:0] d;
		for (int g = 0; g < STAGES; g++) begin
			if (g == 0) begin
				r = '0;
				q = '0;
				d = rad;
			end else begin
				r = rem_s[g-1];
				q = root_s[g-1];
				d = rad_s[g-1];
			end
			for (int i = 0; i < 2; i++) begin
				r     = {r[33:0], d[63:62]};
				d     = {d[61:0], 2'b00};
				trial = {2'b00, q, 2'b01};
				if (r >= trial) begin
					r = r - trial;
					q = {q[30:0], 1'b1};
				end else begin
					q = {q[30:0], 1'b0};
				end
			end
			rem_n[g]  = r;
			root_n[g] = q;
			rad_n[g]  = d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[STAGES-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int g = 0; g < STAGES; g++) begin
				rem_s[g]  <= rem_n[g];
				root_s[g] <= root_n[g];
				rad_s[g]  <= rad_n[g];
				side_s[g] <= (g == 0) ? side_in : side_s[g-1];
			end
		end
	end

	assign out_valid = vld_s[STAGES-1];
	assign len       = root_s[STAGES-1];
	assign side_out  = side_s[STAGES-1];

endmodule

[src/lbvs_div.sv]
// Pipelined rounding divide of each normal component by the length, and output register.
module lbvs_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            adv,
	input  logic                            in_valid,
	input  logic [31:0]                     len,
	input  lbvs_pkg::side_t                 side_in,
	output logic                            out_valid,
	output logic [lbvs_pkg::ROWS-1:0][31:0] pos,
	output logic [lbvs_pkg::ROWS-1:0][15:0] nrm,
	output logic                            zero
);

	localparam int R = lbvs_pkg::ROWS;
	localparam int STEPS = 15;
	localparam int STAGES = (STEPS + 1) / 2;

	logic [STAGES-1:0] vld_s;
	logic [32:0]       rem_s  [STAGES][R];
	logic [14:0]       num_s  [STAGES][R];
	logic [14:0]       quo_s  [STAGES][R];
	logic [31:0]       len_s  [STAGES];
	lbvs_pkg::side_t   side_s [STAGES];

	logic [32:0] rem_n [STAGES][R];
	logic [14:0] num_n [STAGES][R];
	logic [14:0] quo_n [STAGES][R];

	logic                v_s9;
	logic [R-1:0][31:0]  pos_s9;
	logic [R-1:0][15:0]  nrm_s9;
	logic                zero_s9;

	// The quotient never exceeds 2^14, so the top of the numerator starts below the divisor.
	always_comb begin
		logic [45:0] numer;
		logic [32:0] r;
		logic [14:0] nm;
		logic [14:0] q;
		logic [31:0] d;
		for (int g = 0; g < STAGES; g++) begin
			for (int l = 0; l < R; l++) begin
				if (g == 0) begin
					numer = {1'b0, side_in.mag[l], 14'b0} + {15'b0, len[31:1]};
					r     = 33'(numer[45:15]);
					nm    = numer[14:0];
					q     = '0;
					d     = len;
				end else begin
					numer = '0;
					r     = rem_s[g-1][l];
					nm    = num_s[g-1][l];
					q     = quo_s[g-1][l];
					d     = len_s[g-1];
				end
				for (int s = 0; s < 2; s++) begin
					if (2*g + s < STEPS) begin
						r  = {r[31:0], nm[14]};
						nm = {nm[13:0], 1'b0};
						if (r >= {1'b0, d}) begin
							r = r - {1'b0, d};
							q = {q[13:0], 1'b1};
						end else begin
							q = {q[13:0], 1'b0};
						end
					end
				end
				rem_n[g][l] = r;
				num_n[g][l] = nm;
				quo_n[g][l] = q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
			v_s9  <= 1'b0;
		end else if (adv) begin
			vld_s <= {vld_s[STAGES-2:0], in_valid};
			v_s9  <= vld_s[STAGES-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int g = 0; g < STAGES; g++) begin
				for (int l = 0; l < R; l++) begin
					rem_s[g][l] <= rem_n[g][l];
					num_s[g][l] <= num_n[g][l];
					quo_s[g][l] <= quo_n[g][l];
				end
				len_s[g]  <= (g == 0) ? len : len_s[g-1];
				side_s[g] <= (g == 0) ? side_in : side_s[g-1];
			end

			pos_s9  <= side_s[STAGES-1].pos;
			zero_s9 <= side_s[STAGES-1].zero;
			for (int l = 0; l < R; l++) begin
				if (side_s[STAGES-1].zero) begin
					nrm_s9[l] <= '0;
				end else if (side_s[STAGES-1].neg[l]) begin
					nrm_s9[l] <= 16'd0 - {1'b0, quo_s[STAGES-1][l]};
				end else begin
					nrm_s9[l] <= {1'b0, quo_s[STAGES-1][l]};
				end
			end
		end
	end

	assign out_valid = v_s9;
	assign pos       = pos_s9;
	assign nrm       = nrm_s9;
	assign zero      = zero_s9;

endmodule

[src/linear_blend_vertex_skinning.sv]
// Linear blend skinning with four bone influences per vertex: top level.
// A load item (op 0) writes one Q16.16 entry of a bone's 3x4 matrix; it gives no result.
// A vertex item (op 1) holds the input busy until its four bones are read, because the
// bone store has a single read port that returns one whole bone matrix per cycle while
// the pipeline advances, and each vertex needs four; no new item is taken meanwhile.
// The rest of the work (blend, transform, square root and divide for the unit normal) is
// a stall-able pipeline that overlaps many vertices. Write every matrix entry a vertex
// uses before that vertex. Results saturate, and a normal that transforms to zero comes
// out as zero with zero_normal set.
module linear_blend_vertex_skinning #(
	parameter int NUM_BONES = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               op,
	input  logic [5:0]         bone_slot,
	input  logic [3:0]         entry_index,
	input  logic signed [31:0] entry_value,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic signed [15:0] nrm_x,
	input  logic signed [15:0] nrm_y,
	input  logic signed [15:0] nrm_z,
	input  logic [63:0]        weights_packed,
	input  logic [23:0]        bones_packed,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] out_pos_x,
	output logic signed [31:0] out_pos_y,
	output logic signed [31:0] out_pos_z,
	output logic signed [15:0] out_nrm_x,
	output logic signed [15:0] out_nrm_y,
	output logic signed [15:0] out_nrm_z,
	output logic               zero_normal
);

	logic                                   adv;
	logic                                   t_valid;
	lbvs_pkg::mat_t                         t;
	lbvs_pkg::vtx_t                         vtx;
	logic                                   x_valid;
	logic [63:0]                            rad;
	lbvs_pkg::side_t                        x_side;
	logic                                   q_valid;
	logic [31:0]                            len;
	lbvs_pkg::side_t                        q_side;
	logic [lbvs_pkg::ROWS-1:0][31:0]        pos;
	logic [lbvs_pkg::ROWS-1:0][15:0]        nrm;

	// The whole pipeline moves together whenever the output register is free or drains.
	assign adv = ~out_valid | out_ready;

	lbvs_blend #(
		.NUM_BONES(NUM_BONES)
	) u_blend (
		.clk           (clk),
		.arst_n        (arst_n),
		.adv           (adv),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.op            (op),
		.bone_slot     (bone_slot),
		.entry_index   (entry_index),
		.entry_value   (entry_value),
		.pos_x         (pos_x),
		.pos_y         (pos_y),
		.pos_z         (pos_z),
		.nrm_x         (nrm_x),
		.nrm_y         (nrm_y),
		.nrm_z         (nrm_z),
		.weights_packed(weights_packed),
		.bones_packed  (bones_packed),
		.t_valid       (t_valid),
		.t             (t),
		.vtx           (vtx)
	);

	lbvs_xform u_xform (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (t_valid),
		.t        (t),
		.vtx      (vtx),
		.out_valid(x_valid),
		.rad      (rad),
		.side     (x_side)
	);

	lbvs_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (x_valid),
		.rad      (rad),
		.side_in  (x_side),
		.out_valid(q_valid),
		.len      (len),
		.side_out (q_side)
	);

	lbvs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (q_valid),
		.len      (len),
		.side_in  (q_side),
		.out_valid(out_valid),
		.pos      (pos),
		.nrm      (nrm),
		.zero     (zero_normal)
	);

	assign out_pos_x = pos[0];
	assign out_pos_y = pos[1];
	assign out_pos_z = pos[2];
	assign out_nrm_x = nrm[0];
	assign out_nrm_y = nrm[1];
	assign out_nrm_z = nrm[2];

endmodule

[bench/tb_top.sv]
// Self-checking testbench for the four-influence linear blend skinning block.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NBONES = 64;
	localparam int STALL_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 80;
	localparam int NUM_ITEMS = 1200;

	typedef struct {
		lbvs_pkg::op_t op;
		bit [5:0]      slot;
		bit [3:0]      eidx;
		int            val;
		int            pos[3];
		shortint       nrm[3];
		bit [63:0]     wts;
		bit [23:0]     bones;
	} item_t;

	typedef struct {
		int      pos[3];
		shortint nrm[3];
		bit      zn;
	} vres_t;

	// Holds the bone store mirror and the skinned vertices still owed by the block.
	class skin_scoreboard;
		int    bone_store[NBONES*lbvs_pkg::ENTRIES];
		vres_t owed[$];
		int    errors;

		function longint clamp32(longint x);
			if (x > 64'sd2147483647) return 64'sd2147483647;
			if (x < -64'sd2147483648) return -64'sd2147483648;
			return x;
		endfunction

		function longint unsigned int_sqrt(longint unsigned x);
			longint unsigned res, bitv;
			res = 0;
			bitv = 64'd1 << 62;
			while (bitv > x) bitv >>= 2;
			while (bitv != 0) begin
				if (x >= res + bitv) begin
					x -= res + bitv;
					res = (res >> 1) + bitv;
				end else begin
					res >>= 1;
				end
				bitv >>= 2;
			end
			return res;
		endfunction

		function vres_t skin(item_t it);
			vres_t           r;
			longint          t[lbvs_pkg::ENTRIES];
			longint          v[3];
			longint          acc, hi, lo, prod, h, m, w, q;
			longint unsigned sq, len, a;
			int              b;
			for (int e = 0; e < lbvs_pkg::ENTRIES; e++) begin
				acc = 0;
				for (int k = 0; k < lbvs_pkg::INFLUENCES; k++) begin
					w = longint'({48'b0, it.wts[16*k +: 16]});
					b = int'(it.bones[6*k +: 6]);
					if (b < NBONES)
						acc += w * longint'(bone_store[b*lbvs_pkg::ENTRIES + e]);
				end
				t[e] = clamp32((acc + 16384) >>> 15);
			end
			for (int row = 0; row < 3; row++) begin
				hi = 0;
				lo = 0;
				v[row] = 0;
				for (int c = 0; c < 3; c++) begin
					prod = t[4*row + c] * longint'(it.pos[c]);
					h = prod >>> 16;
					hi += h;
					lo += prod - h * 65536;
					v[row] += t[4*row + c] * longint'(it.nrm[c]);
				end
				r.pos[row] = int'(clamp32(hi + ((lo + 32768) >>> 16) + t[4*row + 3]));
			end
			if (v[0] == 0 && v[1] == 0 && v[2] == 0) begin
				r.nrm = '{0, 0, 0};
				r.zn = 1'b1;
				return r;
			end
			m = 0;
			for (int row = 0; row < 3; row++) begin
				a = (v[row] < 0) ? -v[row] : v[row];
				if (longint'(a) > m) m = a;
			end
			// Bring the largest component into [2^29, 2^30) before the square root.
			while (m >= (64'sd1 << 30)) begin
				for (int row = 0; row < 3; row++) v[row] = v[row] >>> 1;
				m = m >>> 1;
			end
			while (m < (64'sd1 << 29)) begin
				for (int row = 0; row < 3; row++) v[row] = v[row] * 2;
				m = m * 2;
			end
			sq = 0;
			for (int row = 0; row < 3; row++) begin
				a = (v[row] < 0) ? -v[row] : v[row];
				sq += a * a;
			end
			len = int_sqrt(sq);
			if (len == 0) len = 1;
			for (int row = 0; row < 3; row++) begin
				a = (v[row] < 0) ? -v[row] : v[row];
				q = longint'((a * 16384 + len / 2) / len);
				if (v[row] < 0) q = -q;
				r.nrm[row] = shortint'(q);
			end
			r.zn = 1'b0;
			return r;
		endfunction

		function void note_transfer(item_t it);
			if (it.op == lbvs_pkg::OP_LOAD) begin
				if (it.eidx < lbvs_pkg::ENTRIES)
					bone_store[it.slot*lbvs_pkg::ENTRIES + it.eidx] = it.val;
			end else begin
				owed.push_back(skin(it));
			end
		endfunction

		function void report(string name, longint exp_v, longint act_v);
			if (exp_v != act_v) begin
				$display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, exp_v,
					act_v);
				errors++;
			end
		endfunction

		function void check_result(vres_t act);
			vres_t e;
			if (owed.size() == 0) begin
				$display("%0t ns: result with nothing expected, got pos %0d %0d %0d", $time,
					act.pos[0], act.pos[1], act.pos[2]);
				errors++;
				return;
			end
			e = owed.pop_front();
			report("out_pos_x", e.pos[0], act.pos[0]);
			report("out_pos_y", e.pos[1], act.pos[1]);
			report("out_pos_z", e.pos[2], act.pos[2]);
			report("out_nrm_x", e.nrm[0], act.nrm[0]);
			report("out_nrm_y", e.nrm[1], act.nrm[1]);
			report("out_nrm_z", e.nrm[2], act.nrm[2]);
			report("zero_normal", e.zn, act.zn);
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic               op = 1'b0;
	logic [5:0]         bone_slot = '0;
	logic [3:0]         entry_index = '0;
	logic signed [31:0] entry_value = '0;
	logic signed [31:0] pos_x = '0, pos_y = '0, pos_z = '0;
	logic signed [15:0] nrm_x = '0, nrm_y = '0, nrm_z = '0;
	logic [63:0]        weights_packed = '0;
	logic [23:0]        bones_packed = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic signed [31:0] out_pos_x, out_pos_y, out_pos_z;
	logic signed [15:0] out_nrm_x, out_nrm_y, out_nrm_z;
	logic               zero_normal;

	skin_scoreboard sb = new();
	bit             written[NBONES][lbvs_pkg::ENTRIES];
	bit             calm;
	int             idle_cycles;
	int             out_stall;

	linear_blend_vertex_skinning #(.NUM_BONES(NBONES)) dut (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic int pick_gap();
		int r;
		if (calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic int rand_word();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) return $urandom_range(0, 1 << 18) - (1 << 17);
		if (r < 88) return $urandom;
		case ($urandom_range(0, 4))
			0: return 0;
			1: return 32'sh7fffffff;
			2: return 32'sh80000000;
			3: return 65536;
			default: return -65536;
		endcase
	endfunction

	function automatic shortint rand_nrm();
		int r;
		r = $urandom_range(0, 99);
		if (r < 5) return 0;
		if (r < 15) return shortint'($urandom_range(0, 8) - 4);
		return shortint'($urandom);
	endfunction

	function automatic item_t rand_item();
		item_t it;
		it.op = lbvs_pkg::op_t'($urandom_range(0, 1));
		it.slot = 6'($urandom);
		it.eidx = 4'($urandom);
		it.val = rand_word();
		for (int c = 0; c < 3; c++) begin
			it.pos[c] = ($urandom_range(0, 3) == 0) ? $urandom
				: ($urandom_range(0, 1 << 22) - (1 << 21));
			it.nrm[c] = rand_nrm();
		end
		it.wts = {$urandom, $urandom};
		it.bones = 24'($urandom);
		return it;
	endfunction

	function automatic item_t load_item(int slot, int e, int val);
		item_t it;
		it = rand_item();
		it.op = lbvs_pkg::OP_LOAD;
		it.slot = 6'(slot);
		it.eidx = 4'(e);
		it.val = val;
		return it;
	endfunction

	function automatic void r_stall();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10) out_stall = $urandom_range(1, 3);
		else if (r < 12) out_stall = $urandom_range(10, 50);
	endfunction

	task automatic drive(item_t it);
		int g;
		g = pick_gap();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= it.op;
		bone_slot <= it.slot;
		entry_index <= it.eidx;
		entry_value <= it.val;
		pos_x <= it.pos[0];
		pos_y <= it.pos[1];
		pos_z <= it.pos[2];
		nrm_x <= it.nrm[0];
		nrm_y <= it.nrm[1];
		nrm_z <= it.nrm[2];
		weights_packed <= it.wts;
		bones_packed <= it.bones;
		do @(posedge clk); while (!in_ready);
		sb.note_transfer(it);
		if (it.op == lbvs_pkg::OP_LOAD && it.eidx < lbvs_pkg::ENTRIES)
			written[it.slot][it.eidx] = 1'b1;
	endtask

	// Vertices only address bones whose twelve entries have all been written.
	task automatic drive_vertex(item_t it, bit keep_bones);
		int full[$];
		bit ok;
		for (int s = 0; s < NBONES; s++) begin
			ok = 1'b1;
			for (int e = 0; e < lbvs_pkg::ENTRIES; e++) ok &= written[s][e];
			if (ok) full.push_back(s);
		end
		it.op = lbvs_pkg::OP_SKIN;
		if (!keep_bones) begin
			for (int k = 0; k < lbvs_pkg::INFLUENCES; k++)
				it.bones[6*k +: 6] = 6'(full[$urandom_range(0, full.size() - 1)]);
			case ($urandom_range(0, 3))
				0: it.wts = {4{16'(32768 / 4)}};
				1: it.wts = {48'b0, 16'd32768};
				2: it.wts = {16'(32768 - 3 * 8000), 16'd8000, 16'd8000, 16'd8000};
				default: ;
			endcase
		end
		drive(it);
	endtask

	task automatic load_bone(int slot);
		int order[lbvs_pkg::ENTRIES];
		int j, tmp;
		for (int e = 0; e < lbvs_pkg::ENTRIES; e++) order[e] = e;
		for (int e = lbvs_pkg::ENTRIES - 1; e > 0; e--) begin
			j = $urandom_range(0, e);
			tmp = order[e];
			order[e] = order[j];
			order[j] = tmp;
		end
		for (int e = 0; e < lbvs_pkg::ENTRIES; e++)
			drive(load_item(slot, order[e], rand_word()));
	endtask

	task automatic run_stimulus();
		item_t it;
		int    sent, r, slot;
		// Bone 0 is the identity, bone 1 alternates the most positive and most
		// negative entries.
		for (int e = 0; e < lbvs_pkg::ENTRIES; e++)
			drive(load_item(0, e, (e % 5 == 0) ? 65536 : 0));
		for (int e = 0; e < lbvs_pkg::ENTRIES; e++)
			drive(load_item(1, e, (e % 2) ? 32'sh80000000 : 32'sh7fffffff));
		// Loads past the last matrix entry are dropped.
		drive(load_item(0, 12, 32'sh7fffffff));
		drive(load_item(1, 15, 32'sh12345678));
		it = rand_item();
		it.wts = {48'b0, 16'd32768};
		it.bones = '0;
		it.pos = '{32'sh7fffffff, 32'sh80000000, 0};
		it.nrm = '{16384, 0, 0};
		drive_vertex(it, 1'b1);
		it.nrm = '{0, 0, 0};
		drive_vertex(it, 1'b1);
		it.nrm = '{1, 0, 0};
		drive_vertex(it, 1'b1);
		it.nrm = '{-32768, -32768, -32768};
		it.wts = {4{16'h4000}};
		drive_vertex(it, 1'b1);
		it.wts = '1;
		it.bones = {4{6'd1}};
		it.pos = '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff};
		it.nrm = '{32767, -32768, 32767};
		drive_vertex(it, 1'b1);
		it.pos = '{32'sh80000000, 32'sh80000000, 32'sh80000000};
		drive_vertex(it, 1'b1);
		sent = 0;
		slot = 2;
		while (sent < NUM_ITEMS) begin
			if ($urandom_range(0, 199) == 0) calm = !calm;
			r = $urandom_range(0, 99);
			if (r < 8) begin
				if (slot < NBONES && $urandom_range(0, 1)) begin
					load_bone(slot);
					slot++;
				end else begin
					load_bone($urandom_range(0, NBONES - 1));
				end
				sent += lbvs_pkg::ENTRIES;
			end else if (r < 16) begin
				drive(load_item($urandom_range(0, NBONES - 1), $urandom_range(0, 15),
					rand_word()));
				sent++;
			end else begin
				drive_vertex(rand_item(), 1'b0);
				sent++;
			end
		end
		in_valid <= 1'b0;
	endtask

	always @(posedge clk) begin
		vres_t act;
		if (out_valid && out_ready) begin
			act.pos = '{out_pos_x, out_pos_y, out_pos_z};
			act.nrm = '{out_nrm_x, out_nrm_y, out_nrm_z};
			act.zn = zero_normal;
			sb.check_result(act);
		end
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (out_stall > 0) begin
			out_stall--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			if (!calm) begin
				r_stall();
			end
		end
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles = 0;
		end else if (arst_n) begin
			idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_stimulus();
		while (sb.owed.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.owed.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

[linear_blend_vertex_skinning.f]
src/lbvs_pkg.sv
src/lbvs_blend.sv
src/lbvs_xform.sv
src/lbvs_sqrt.sv
src/lbvs_div.sv
src/linear_blend_vertex_skinning.sv
bench/tb_top.sv
